### hw/rtl/spq_pkg.sv
// Shared constants, codes and types for the sorted priority queue.
`default_nettype none
package spq_pkg;

    localparam int CAPACITY    = 16;
    localparam int FILL_W      = $clog2(CAPACITY + 1);
    localparam int IDX_W       = $clog2(CAPACITY);
    localparam int DATA_W      = 32;
    localparam int COUNT_W     = 5;
    localparam int COUNT_EXT_W = FILL_W + COUNT_W;

    typedef enum logic {
        KIND_INSERT = 1'b0,
        KIND_REMOVE = 1'b1
    } t_kind;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // controller -> datapath
    typedef struct packed {
        logic load;   // capture the incoming word
        logic exec;   // apply the captured word and load the output register
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic out_blocked;  // output register holds a word that is not taken this cycle
    } t_stat;

endpackage
`default_nettype wire

### hw/rtl/spq_if.sv
// Handshake channels for operation words and result words.
`default_nettype none
interface spq_in_if;
    logic                              valid;
    logic                              ready;
    spq_pkg::t_kind                    kind;
    logic signed [spq_pkg::DATA_W-1:0] value;

    modport source (output valid, output kind, output value, input ready);
    modport sink   (input valid, input kind, input value, output ready);
endinterface

interface spq_out_if;
    logic                               valid;
    logic                               ready;
    spq_pkg::t_status                   status;
    logic signed [spq_pkg::DATA_W-1:0]  removed_value;
    logic        [spq_pkg::COUNT_W-1:0] count;

    modport source (output valid, output status, output removed_value, output count,
                    input ready);
    modport sink   (input valid, input status, input removed_value, input count,
                    output ready);
endinterface
`default_nettype wire

### hw/rtl/sorted_priority_queue_unit.sv
// Top level of the sorted priority queue: controller plus datapath.
//
//  channel  dir  word contents                     handshake
//  i_in     in   kind, value                       valid / ready
//  o_out    out  status, removed_value, count      valid / ready
//
// An operation word is captured in the accept step and applied in the execute
// step, so the queue takes no new word until the last one has been applied.
// Inserts compare and shift all cells in one step.
// The execute step waits while the output register holds an untaken result.
// Reset empties the queue (fill count zero) and drops any pending result.
`default_nettype none
module sorted_priority_queue_unit (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    spq_in_if.sink    i_in,
    spq_out_if.source o_out
);

    spq_pkg::t_cmd  w_cmd;
    spq_pkg::t_stat w_stat;
    logic           w_in_ready;

    assign i_in.ready = w_in_ready;

    spq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (w_in_ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    spq_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_kind          (i_in.kind),
        .i_value         (i_in.value),
        .i_cmd           (w_cmd),
        .o_stat          (w_stat),
        .o_out_valid     (o_out.valid),
        .i_out_ready     (o_out.ready),
        .o_status        (o_out.status),
        .o_removed_value (o_out.removed_value),
        .o_count         (o_out.count)
    );

endmodule
`default_nettype wire

### hw/rtl/spq_ctrl.sv
// Controller: accept / execute sequencing for the sorted priority queue.
`default_nettype none
module spq_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_ready,
    input  wire spq_pkg::t_stat i_stat,
    output spq_pkg::t_cmd       o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            S_IDLE: begin
                // no word is taken while reset is held
                o_in_ready = i_rst_n;
                if (i_in_valid && i_rst_n) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                if (!i_stat.out_blocked) begin
                    o_cmd.exec = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule
`default_nettype wire

### hw/rtl/spq_dp.sv
// Datapath: sorted cell row, fill count and output register.
`default_nettype none
module spq_dp (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire spq_pkg::t_kind                    i_kind,
    input  wire logic signed [spq_pkg::DATA_W-1:0] i_value,
    input  wire spq_pkg::t_cmd                     i_cmd,
    output spq_pkg::t_stat                         o_stat,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_ready,
    output spq_pkg::t_status                       o_status,
    output logic signed [spq_pkg::DATA_W-1:0]      o_removed_value,
    output logic        [spq_pkg::COUNT_W-1:0]     o_count
);

    // cells hold values in descending order, cell 0 the largest
    logic signed [spq_pkg::DATA_W-1:0]      r_cell [spq_pkg::CAPACITY];
    logic signed [spq_pkg::DATA_W-1:0]      n_cell [spq_pkg::CAPACITY];
    logic        [spq_pkg::CAPACITY-1:0]    w_keep;
    logic        [spq_pkg::FILL_W-1:0]      r_fill, n_fill;
    logic        [spq_pkg::FILL_W-1:0]      w_last;
    logic        [spq_pkg::COUNT_EXT_W-1:0] w_fill_ext;

    spq_pkg::t_kind                    r_kind;
    logic signed [spq_pkg::DATA_W-1:0] r_value;

    logic                                   r_out_valid;
    spq_pkg::t_status                       r_status, n_status;
    logic signed [spq_pkg::DATA_W-1:0]      r_removed, n_removed;
    logic        [spq_pkg::COUNT_W-1:0]     r_count;
    logic                                   w_full, w_empty, w_ins_write;

    assign w_full  = (r_fill == spq_pkg::FILL_W'(spq_pkg::CAPACITY));
    assign w_empty = (r_fill == '0);
    assign w_last  = r_fill - 1'b1;

    // a cell keeps its value when it is occupied and not below the new value;
    // equal values stay ahead of the new one
    always_comb begin
        for (int i = 0; i < spq_pkg::CAPACITY; i++) begin
            w_keep[i] = (spq_pkg::FILL_W'(i) < r_fill) && (r_cell[i] >= r_value);
        end
    end

    // every cell past the insert point takes its upper neighbor
    always_comb begin
        n_cell[0] = w_keep[0] ? r_cell[0] : r_value;
        for (int i = 1; i < spq_pkg::CAPACITY; i++) begin
            if (w_keep[i]) begin
                n_cell[i] = r_cell[i];
            end else if (w_keep[i-1]) begin
                n_cell[i] = r_value;
            end else begin
                n_cell[i] = r_cell[i-1];
            end
        end
    end

    always_comb begin
        n_fill      = r_fill;
        n_status    = spq_pkg::ST_DONE;
        n_removed   = '0;
        w_ins_write = 1'b0;
        case (r_kind)
            spq_pkg::KIND_INSERT: begin
                if (w_full) begin
                    n_status = spq_pkg::ST_FULL;
                end else begin
                    w_ins_write = 1'b1;
                    n_fill      = r_fill + 1'b1;
                end
            end
            spq_pkg::KIND_REMOVE: begin
                if (w_empty) begin
                    n_status = spq_pkg::ST_EMPTY;
                end else begin
                    n_fill    = w_last;
                    n_removed = r_cell[w_last[spq_pkg::IDX_W-1:0]];
                end
            end
            default: begin
                n_status = spq_pkg::ST_DONE;
            end
        endcase
    end

    assign w_fill_ext = spq_pkg::COUNT_EXT_W'(n_fill);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind  <= i_kind;
            r_value <= i_value;
        end
        if (i_cmd.exec) begin
            r_status  <= n_status;
            r_removed <= n_removed;
            r_count   <= w_fill_ext[spq_pkg::COUNT_W-1:0];
        end
        if (i_cmd.exec && w_ins_write) begin
            for (int i = 0; i < spq_pkg::CAPACITY; i++) begin
                r_cell[i] <= n_cell[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.exec) begin
                r_fill      <= n_fill;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_stat.out_blocked = r_out_valid && !i_out_ready;
    assign o_out_valid        = r_out_valid;
    assign o_status           = r_status;
    assign o_removed_value    = r_removed;
    assign o_count            = r_count;

endmodule
`default_nettype wire

### verif/tb.sv
// Self-checking testbench for sorted_priority_queue_unit: directed table plus random traffic.
module tb;

    localparam int RANDOM_OPS   = 1675;
    localparam int STALL_LIMIT  = 3000;
    localparam int HOLD_CYCLES  = 150;
    localparam int DRAIN_CYCLES = 20;

    typedef struct packed {
        spq_pkg::t_status                   status;
        logic signed [spq_pkg::DATA_W-1:0]  removed;
        logic        [spq_pkg::COUNT_W-1:0] count;
    } t_result;

    typedef struct {
        spq_pkg::t_kind                    kind;
        logic signed [spq_pkg::DATA_W-1:0] value;
        bit                                pinned;
        t_result                           res;
    } t_op_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    int unsigned cycle = 0;
    int unsigned quiet_cycles = 0;
    int unsigned err_cnt = 0;
    wire         calm = (cycle >= 2000) && (cycle < 2600);

    spq_in_if  in_ch ();
    spq_out_if out_ch ();

    sorted_priority_queue_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    always #5 i_clk = ~i_clk;

    // shadow copy of the queue, slot 0 largest
    logic signed [spq_pkg::DATA_W-1:0] shadow_slot [spq_pkg::CAPACITY];
    int                                shadow_fill = 0;
    t_result                           results_due [$];

    function automatic t_result predict_op(spq_pkg::t_kind k,
                                           logic signed [spq_pkg::DATA_W-1:0] v);
        t_result r;
        int      pos;
        r = '{spq_pkg::ST_DONE, '0, '0};
        if (k == spq_pkg::KIND_INSERT) begin
            if (shadow_fill >= spq_pkg::CAPACITY) begin
                r.status = spq_pkg::ST_FULL;
            end else begin
                pos = shadow_fill;
                while (pos > 0 && shadow_slot[pos-1] < v) begin
                    shadow_slot[pos] = shadow_slot[pos-1];
                    pos--;
                end
                shadow_slot[pos] = v;
                shadow_fill++;
            end
        end else if (shadow_fill == 0) begin
            r.status = spq_pkg::ST_EMPTY;
        end else begin
            shadow_fill--;
            r.removed = shadow_slot[shadow_fill];
        end
        r.count = spq_pkg::COUNT_W'(shadow_fill);
        return r;
    endfunction

    // mix of wide random, clustered small values (duplicates) and extremes
    function automatic logic signed [spq_pkg::DATA_W-1:0] pick_value();
        logic signed [spq_pkg::DATA_W-1:0] v;
        case ($urandom_range(3))
            0: v = $signed($urandom_range(15)) - 8;
            1: begin
                case ($urandom_range(3))
                    0: v = 32'h8000_0000;
                    1: v = 32'h7FFF_FFFF;
                    2: v = '0;
                    default: v = '1;
                endcase
            end
            default: v = $urandom;
        endcase
        return v;
    endfunction

    task automatic send_word(spq_pkg::t_kind k, logic signed [spq_pkg::DATA_W-1:0] v,
                             bit pinned, t_result pinned_res);
        t_result r;
        while (!calm && $urandom_range(99) < 21) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.kind  <= k;
        in_ch.value <= v;
        do @(posedge i_clk); while (!in_ch.ready);
        r = predict_op(k, v);
        results_due.push_back(pinned ? pinned_res : r);
    endtask

    t_op_row directed_ops [25] = '{
        '{spq_pkg::KIND_REMOVE, 32'h0000_0000, 1'b1, '{spq_pkg::ST_EMPTY, 32'h0, 5'd0}},
        '{spq_pkg::KIND_INSERT, 32'h7FFF_FFFF, 1'b1, '{spq_pkg::ST_DONE,  32'h0, 5'd1}},
        '{spq_pkg::KIND_INSERT, 32'h8000_0000, 1'b1, '{spq_pkg::ST_DONE,  32'h0, 5'd2}},
        '{spq_pkg::KIND_INSERT, 32'h0000_0000, 1'b1, '{spq_pkg::ST_DONE,  32'h0, 5'd3}},
        '{spq_pkg::KIND_INSERT, 32'hFFFF_FFFF, 1'b1, '{spq_pkg::ST_DONE,  32'h0, 5'd4}},
        '{spq_pkg::KIND_INSERT, 32'h0000_0000, 1'b1, '{spq_pkg::ST_DONE,  32'h0, 5'd5}},
        '{spq_pkg::KIND_REMOVE, 32'h0000_0000, 1'b1,
          '{spq_pkg::ST_DONE, 32'h8000_0000, 5'd4}},
        '{spq_pkg::KIND_REMOVE, 32'h5555_AAAA, 1'b1,
          '{spq_pkg::ST_DONE, 32'hFFFF_FFFF, 5'd3}},
        '{spq_pkg::KIND_INSERT, 32'h0000_0001, 1'b0, '{spq_pkg::ST_DONE,  32'h0, 5'd0}},
        '{spq_pkg::KIND_INSERT, 32'hAAAA_AAAA, 1'b0, '{spq_pkg::ST_DONE,  32'h0, 5'd0}},
        '{spq_pkg::KIND_INSERT, 32'h5555_5555, 1'b0, '{spq_pkg::ST_DONE,  32'h0, 5'd0}},
        '{spq_pkg::KIND_INSERT, 32'h7FFF_FFFF, 1'b0, '{spq_pkg::ST_DONE,  32'h0, 5'd0}},
        '{spq_pkg::KIND_INSERT, 32'h8000_0001, 1'b0, '{spq_pkg::ST_DONE,  32'h0, 5'd0}},
        '{spq_pkg::KIND_INSERT, 32'h1234_5678, 1'b0, '{spq_pkg::ST_DONE,  32'h0, 5'd0}},
        '{spq_pkg::KIND_INSERT, 32'hFEDC_BA98, 1'b0, '{spq_pkg::ST_DONE,  32'h0, 5'd0}},
        '{spq_pkg::KIND_INSERT, 32'h0000_0100, 1'b0, '{spq_pkg::ST_DONE,  32'h0, 5'd0}},
        '{spq_pkg::KIND_INSERT, 32'hFFFF_FF00, 1'b0, '{spq_pkg::ST_DONE,  32'h0, 5'd0}},
        '{spq_pkg::KIND_INSERT, 32'h4000_0000, 1'b0, '{spq_pkg::ST_DONE,  32'h0, 5'd0}},
        '{spq_pkg::KIND_INSERT, 32'hC000_0000, 1'b0, '{spq_pkg::ST_DONE,  32'h0, 5'd0}},
        '{spq_pkg::KIND_INSERT, 32'h0000_0000, 1'b0, '{spq_pkg::ST_DONE,  32'h0, 5'd0}},
        '{spq_pkg::KIND_INSERT, 32'h8000_0000, 1'b0, '{spq_pkg::ST_DONE,  32'h0, 5'd0}},
        // queue full now: word dropped
        '{spq_pkg::KIND_INSERT, 32'h0F0F_0F0F, 1'b1, '{spq_pkg::ST_FULL,  32'h0, 5'd16}},
        '{spq_pkg::KIND_REMOVE, 32'h0000_0000, 1'b1,
          '{spq_pkg::ST_DONE, 32'h8000_0000, 5'd15}},
        '{spq_pkg::KIND_INSERT, 32'h8000_0000, 1'b0, '{spq_pkg::ST_DONE,  32'h0, 5'd0}},
        '{spq_pkg::KIND_REMOVE, 32'hFFFF_FFFF, 1'b1,
          '{spq_pkg::ST_DONE, 32'h8000_0000, 5'd15}}
    };

    // operation source
    initial begin : op_source
        int             insert_pct;
        spq_pkg::t_kind k;
        insert_pct   = 50;
        in_ch.valid  = 1'b0;
        in_ch.kind   = spq_pkg::KIND_INSERT;
        in_ch.value  = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_ops[i])
            send_word(directed_ops[i].kind, directed_ops[i].value, directed_ops[i].pinned,
                      directed_ops[i].res);

        // phases drift between filling, draining and balanced traffic
        for (int n = 0; n < RANDOM_OPS; n++) begin
            if (n % 40 == 0) begin
                case ($urandom_range(2))
                    0: insert_pct = 15;
                    1: insert_pct = 50;
                    default: insert_pct = 85;
                endcase
            end
            k = ($urandom_range(99) < insert_pct) ? spq_pkg::KIND_INSERT : spq_pkg::KIND_REMOVE;
            send_word(k, pick_value(), 1'b0, '{spq_pkg::ST_DONE, '0, '0});
        end
        in_ch.valid <= 1'b0;

        while (results_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (err_cnt == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // result sink: random stalls plus long hold-offs that back up the queue input
    initial begin : result_sink
        int hold_left = 0;
        out_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (cycle == 1200 || cycle == 3200) hold_left = HOLD_CYCLES;
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= calm || ($urandom_range(99) >= 21);
            end
        end
    end

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (results_due.size() == 0) begin
                err_cnt++;
                $display("%0t: unexpected result word status %0d value %0d count %0d",
                         $time, out_ch.status, out_ch.removed_value, out_ch.count);
            end else begin
                want = results_due.pop_front();
                if (out_ch.status !== want.status || out_ch.removed_value !== want.removed
                    || out_ch.count !== want.count) begin
                    err_cnt++;
                    $display("%0t: expected status %0d value %0d count %0d, got %0d %0d %0d",
                             $time, want.status, want.removed, want.count,
                             out_ch.status, out_ch.removed_value, out_ch.count);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle <= cycle + 1;
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end
    end

endmodule
